@@ sv/yms_pkg.sv @@
package yms_pkg;

	// Block sizes and name limit.
	localparam int unsigned LONG_BLOCK  = 1024;
	localparam int unsigned SHORT_BLOCK = 128;
	localparam int unsigned NAME_MAX    = 128;

	localparam int unsigned STORE_AW = $clog2(LONG_BLOCK);

	// Protocol bytes.
	localparam logic [7:0] B_SOH  = 8'h01;
	localparam logic [7:0] B_STX  = 8'h02;
	localparam logic [7:0] B_EOT  = 8'h04;
	localparam logic [7:0] B_ACK  = 8'h06;
	localparam logic [7:0] B_NAK  = 8'h15;
	localparam logic [7:0] B_C    = 8'h43;
	localparam logic [7:0] B_PAD  = 8'h1A;
	localparam logic [7:0] B_FILL = 8'h55;
	localparam logic [7:0] B_ZERO = 8'd48;

	// Input kinds.
	localparam logic [2:0] K_START = 3'd0;
	localparam logic [2:0] K_LOAD  = 3'd1;
	localparam logic [2:0] K_RX    = 3'd2;
	localparam logic [2:0] K_POLL  = 3'd3;
	localparam logic [2:0] K_TICK  = 3'd4;
	localparam logic [2:0] K_READY = 3'd5;

	// Protocol phases.
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_NAME   = 4'd1;
	localparam logic [3:0] PH_WAITC0 = 4'd2;
	localparam logic [3:0] PH_SEND0  = 4'd3;
	localparam logic [3:0] PH_ACKC   = 4'd4;
	localparam logic [3:0] PH_LOAD   = 4'd5;
	localparam logic [3:0] PH_SENDD  = 4'd6;
	localparam logic [3:0] PH_ACKD   = 4'd7;
	localparam logic [3:0] PH_EOTW   = 4'd8;
	localparam logic [3:0] PH_WAITC1 = 4'd9;
	localparam logic [3:0] PH_SENDL  = 4'd10;
	localparam logic [3:0] PH_ACKL   = 4'd11;

	// Outcome codes.
	localparam logic [1:0] OC_NONE    = 2'd0;
	localparam logic [1:0] OC_SUCCESS = 2'd1;
	localparam logic [1:0] OC_TIMEOUT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CONNECT = 2'd0;
	localparam logic [1:0] CFG_ERROR   = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;

	// Power of ten for decimal digit k, most significant digit first.
	function automatic logic [31:0] pow10(input logic [3:0] k);
		case (k)
			4'd0:    pow10 = 32'd1000000000;
			4'd1:    pow10 = 32'd100000000;
			4'd2:    pow10 = 32'd10000000;
			4'd3:    pow10 = 32'd1000000;
			4'd4:    pow10 = 32'd100000;
			4'd5:    pow10 = 32'd10000;
			4'd6:    pow10 = 32'd1000;
			4'd7:    pow10 = 32'd100;
			4'd8:    pow10 = 32'd10;
			default: pow10 = 32'd1;
		endcase
	endfunction

	// CRC-16, polynomial 0x1021, one byte.
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

@@ sv/yms_ram.sv @@
module yms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/ymodem_sender_top.sv @@
// A result is registered: most items give it in the cycle after the transaction; a packet
// data byte first passes through ST_RD, because the packet store has a registered read port.
// The byte that ends the file name passes through ST_NUL and ST_DIG, since the size is
// converted to decimal by repeated subtraction. Other items go at one item per cycle while
// m_tready keeps the result stream moving. Reset (arst_n low) clears all control
// state and restores the register defaults; the packet store is not cleared.
module ymodem_sender_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // tx_valid, tx_byte[8], want_bytes[11], phase[4], outcome[2]
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import yms_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_NUL, ST_DIG} st_t;

	st_t         st_q, n_st;
	logic [15:0] connect_q, error_lim_q;
	logic [31:0] timeout_q;
	logic [3:0]  ph_q, n_ph;
	logic [7:0]  blk_q, n_blk;
	logic [31:0] br_q, n_br;
	logic [10:0] fill_q, n_fill;
	logic [10:0] send_q, n_send;
	logic [15:0] crc_q, n_crc;
	logic [15:0] err_q, n_err;
	logic [31:0] tick_q, n_tick;
	logic        timer_q, n_timer;
	logic        ack_q, n_ack;
	logic [1:0]  outc_q, n_outc;
	logic [31:0] dn_q, n_dn;
	logic [3:0]  dk_q, n_dk;
	logic [3:0]  dd_q, n_dd;
	logic        lead_q, n_lead;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	logic        accept;
	logic [2:0]  kind;
	logic [7:0]  b;
	logic        res;
	logic        txv;
	logic [7:0]  txb;
	logic [10:0] want;
	logic        ram_we;
	logic [STORE_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]  ram_wdata, ram_rdata;
	logic        do_wait;
	logic [3:0]  wait_ph;
	logic        do_fin;
	logic [1:0]  fin_code;
	logic        bad;
	logic        do_emit;
	logic        emit_data;
	logic [7:0]  emit_b;
	logic [10:0] len;
	logic [10:0] need;
	logic [10:0] d_idx;
	logic [31:0] pw;
	logic [15:0] limit;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (st_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign kind      = s_tuser;
	assign b         = s_tdata[7:0];
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign d_idx     = send_q - 11'd3;

	yms_ram #(.WIDTH(8), .DEPTH(LONG_BLOCK)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Block length of the current send phase.
	always_comb begin
		if (ph_q == PH_SENDD) begin
			len = (br_q < 32'(SHORT_BLOCK)) ? 11'(SHORT_BLOCK) : 11'(LONG_BLOCK);
		end else if (ph_q == PH_SEND0) begin
			len = 11'(LONG_BLOCK);
		end else begin
			len = 11'(SHORT_BLOCK);
		end
	end

	// Next state of one step.
	always_comb begin
		n_st = st_q; n_ph = ph_q; n_blk = blk_q; n_br = br_q; n_fill = fill_q;
		n_send = send_q; n_crc = crc_q; n_err = err_q; n_tick = tick_q;
		n_timer = timer_q; n_ack = ack_q; n_outc = outc_q;
		n_dn = dn_q; n_dk = dk_q; n_dd = dd_q; n_lead = lead_q;
		res = 1'b0; txv = 1'b0; txb = 8'h00;
		ram_we = 1'b0; ram_waddr = fill_q[STORE_AW-1:0]; ram_wdata = b;
		ram_raddr = d_idx[STORE_AW-1:0];
		do_wait = 1'b0; wait_ph = PH_IDLE; do_fin = 1'b0; fin_code = OC_NONE;
		bad = 1'b0; do_emit = 1'b0; emit_data = 1'b0; emit_b = 8'h00;
		pw = pow10(dk_q);
		limit = (ph_q == PH_WAITC0) ? connect_q : error_lim_q;

		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					res = 1'b1;
					case (kind)
						K_START: begin
							n_ph = PH_NAME; n_blk = 8'd0; n_br = s_tdata;
							n_fill = 11'd0; n_send = 11'd0; n_crc = 16'd0; n_err = 16'd0;
							n_tick = 32'd0; n_timer = 1'b0; n_ack = 1'b0; n_outc = OC_NONE;
						end
						K_LOAD: begin
							if (ph_q == PH_NAME) begin
								if (b == 8'd0) begin
									res = 1'b0;
									n_st = ST_NUL;
								end else begin
									if (fill_q < 11'(LONG_BLOCK)) begin
										ram_we = 1'b1;
										n_fill = fill_q + 11'd1;
									end
									if (n_fill >= 11'(NAME_MAX)) begin
										res = 1'b0;
										n_st = ST_NUL;
									end
								end
							end else if (ph_q == PH_LOAD) begin
								if (fill_q < 11'(LONG_BLOCK)) begin
									ram_we = 1'b1;
									n_fill = fill_q + 11'd1;
								end
								need = (br_q < 32'(LONG_BLOCK)) ? br_q[10:0] : 11'(LONG_BLOCK);
								if (n_fill >= need) begin
									n_ph = PH_SENDD; n_timer = 1'b0;
									n_send = 11'd0; n_crc = 16'd0;
								end
							end
						end
						K_RX, K_POLL: begin
							case (ph_q)
								PH_WAITC0, PH_WAITC1: begin
									if (kind == K_RX && b == B_C) begin
										if (ph_q == PH_WAITC1) begin
											n_fill = 11'd0;
										end
										n_ph = ph_q + 4'd1; n_timer = 1'b0;
										n_send = 11'd0; n_crc = 16'd0;
									end else begin
										bad = 1'b1;
									end
								end
								PH_ACKC: begin
									if (kind != K_RX) begin
										bad = 1'b1;
									end else if (!ack_q) begin
										if (b == B_ACK) n_ack = 1'b1; else bad = 1'b1;
									end else if (b == B_C) begin
										n_blk = 8'd1;
										n_timer = 1'b0;
										if (br_q == 32'd0) begin
											txv = 1'b1; txb = B_EOT;
											do_wait = 1'b1; wait_ph = PH_EOTW;
										end else begin
											n_ph = PH_LOAD; n_fill = 11'd0;
										end
									end else begin
										bad = 1'b1;
									end
								end
								PH_ACKD: begin
									if (kind == K_RX && b == B_ACK) begin
										// A short block only goes out when less than its
										// length remains, so only a long block leaves a rest.
										if (br_q > 32'(LONG_BLOCK)) begin
											n_br = br_q - 32'(LONG_BLOCK);
										end else begin
											n_br = 32'd0;
										end
										n_blk = blk_q + 8'd1;
										n_timer = 1'b0;
										if (n_br == 32'd0) begin
											txv = 1'b1; txb = B_EOT;
											do_wait = 1'b1; wait_ph = PH_EOTW;
										end else begin
											n_ph = PH_LOAD; n_fill = 11'd0;
										end
									end else if (kind == K_RX && b == B_NAK) begin
										n_ph = PH_SENDD; n_timer = 1'b0;
										n_send = 11'd0; n_crc = 16'd0;
									end else begin
										bad = 1'b1;
									end
								end
								PH_EOTW: begin
									if (kind == K_RX && b == B_NAK) begin
										n_err = 16'd0; txv = 1'b1; txb = B_EOT;
									end else if (kind == K_RX && b == B_ACK) begin
										do_wait = 1'b1; wait_ph = PH_WAITC1;
									end else begin
										bad = 1'b1;
									end
								end
								PH_ACKL: begin
									if (kind == K_RX && b == B_ACK) begin
										do_fin = 1'b1; fin_code = OC_SUCCESS;
									end else begin
										bad = 1'b1;
									end
								end
								default: begin
								end
							endcase
						end
						K_TICK: begin
							if (timer_q && tick_q != 32'd0) begin
								n_tick = tick_q - 32'd1;
								if (n_tick == 32'd0) begin
									do_fin = 1'b1; fin_code = OC_TIMEOUT;
								end
							end
						end
						K_READY: begin
							if (ph_q == PH_SEND0 || ph_q == PH_SENDD || ph_q == PH_SENDL) begin
								if (send_q == 11'd0) begin
									do_emit = 1'b1;
									emit_b = ((ph_q == PH_SENDD && len == 11'(LONG_BLOCK))
										|| ph_q == PH_SEND0) ? B_STX : B_SOH;
								end else if (send_q == 11'd1) begin
									do_emit = 1'b1;
									emit_b = (ph_q == PH_SENDD) ? blk_q : 8'h00;
								end else if (send_q == 11'd2) begin
									do_emit = 1'b1;
									emit_b = (ph_q == PH_SENDD) ? ~blk_q : 8'hFF;
								end else if (send_q < len + 11'd3) begin
									// Data byte: wait for the store read.
									res = 1'b0;
									n_st = ST_RD;
								end else if (send_q == len + 11'd3) begin
									do_emit = 1'b1; emit_b = crc_q[15:8];
								end else begin
									do_emit = 1'b1; emit_b = crc_q[7:0];
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RD: begin
				res = 1'b1;
				do_emit = 1'b1;
				emit_data = 1'b1;
				n_st = ST_IDLE;
				if (d_idx < fill_q) begin
					emit_b = ram_rdata;
				end else if (ph_q == PH_SEND0) begin
					emit_b = B_FILL;
				end else if (ph_q == PH_SENDD) begin
					emit_b = B_PAD;
				end else begin
					emit_b = 8'h00;
				end
			end
			ST_NUL: begin
				// Name terminator, then start the decimal conversion.
				if (fill_q < 11'(LONG_BLOCK)) begin
					ram_we = 1'b1; ram_wdata = 8'h00; n_fill = fill_q + 11'd1;
				end
				n_dn = br_q; n_dk = 4'd0; n_dd = 4'd0; n_lead = 1'b0;
				n_st = ST_DIG;
			end
			ST_DIG: begin
				if (dn_q >= pw) begin
					n_dn = dn_q - pw;
					n_dd = dd_q + 4'd1;
				end else begin
					if (dd_q != 4'd0 || lead_q || dk_q == 4'd9) begin
						if (fill_q < 11'(LONG_BLOCK)) begin
							ram_we = 1'b1; ram_wdata = B_ZERO + {4'd0, dd_q};
							n_fill = fill_q + 11'd1;
						end
						n_lead = 1'b1;
					end
					n_dd = 4'd0;
					n_dk = dk_q + 4'd1;
					if (dk_q == 4'd9) begin
						res = 1'b1;
						n_st = ST_IDLE;
						do_wait = 1'b1; wait_ph = PH_WAITC0;
					end
				end
			end
			default: begin
				n_st = ST_IDLE;
			end
		endcase

		// Common tail of a packet byte.
		if (do_emit) begin
			txv = 1'b1; txb = emit_b;
			if (emit_data) begin
				n_crc = crc_add(crc_q, emit_b);
			end
			n_send = send_q + 11'd1;
			if (n_send >= len + 11'd5) begin
				do_wait = 1'b1; wait_ph = ph_q + 4'd1;
			end
		end

		// Entering a reply wait.
		if (do_wait) begin
			n_ph = wait_ph; n_err = 16'd0; n_ack = 1'b0;
			n_timer = 1'b1; n_tick = timeout_q;
			if (timeout_q == 32'd0) begin
				do_fin = 1'b1; fin_code = OC_TIMEOUT;
			end
		end

		// Error counting.
		if (bad) begin
			n_err = (err_q == 16'hFFFF) ? err_q : err_q + 16'd1;
			if (n_err >= limit) begin
				do_fin = 1'b1; fin_code = OC_TIMEOUT;
			end
		end

		if (do_fin) begin
			n_ph = PH_IDLE; n_timer = 1'b0; n_outc = fin_code;
		end

		// Load bytes still expected after the step.
		need = (n_br < 32'(LONG_BLOCK)) ? n_br[10:0] : 11'(LONG_BLOCK);
		if (n_ph == PH_NAME) begin
			want = (n_fill < 11'(NAME_MAX)) ? 11'(NAME_MAX) - n_fill : 11'd0;
		end else if (n_ph == PH_LOAD) begin
			want = (n_fill < need) ? need - n_fill : 11'd0;
		end else begin
			want = 11'd0;
		end
	end

	// Control state, configuration and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			connect_q <= 16'd60; error_lim_q <= 16'd10; timeout_q <= 32'd1000;
			ph_q <= PH_IDLE; blk_q <= 8'd0; br_q <= 32'd0; fill_q <= 11'd0;
			send_q <= 11'd0; crc_q <= 16'd0; err_q <= 16'd0; tick_q <= 32'd0;
			timer_q <= 1'b0; ack_q <= 1'b0; outc_q <= OC_NONE;
			dn_q <= 32'd0; dk_q <= 4'd0; dd_q <= 4'd0; lead_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= 32'd0;
		end else begin
			st_q <= n_st;
			ph_q <= n_ph; blk_q <= n_blk; br_q <= n_br; fill_q <= n_fill;
			send_q <= n_send; crc_q <= n_crc; err_q <= n_err; tick_q <= n_tick;
			timer_q <= n_timer; ack_q <= n_ack; outc_q <= n_outc;
			dn_q <= n_dn; dk_q <= n_dk; dd_q <= n_dd; lead_q <= n_lead;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CONNECT: connect_q <= cfg_data[15:0];
					CFG_ERROR:   error_lim_q <= cfg_data[15:0];
					CFG_TIMEOUT: timeout_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (res) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q <= {6'd0, n_outc, n_ph, want, txb, txv};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
